/* hw/rtl/filter_expression_tokenizer_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the tokenizer checker
// ---------------------------------------------------------------------------
`ifndef FILTER_EXPRESSION_TOKENIZER_DEFINES_SVH
`define FILTER_EXPRESSION_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define FET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fet_pkg.sv */
// ---------------------------------------------------------------------------
// fet_pkg
// Types, codes and character classes of the filter expression tokenizer.
// ---------------------------------------------------------------------------
package fet_pkg;

    localparam int MAX_EXPR_LEN_DEFAULT = 4096;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_SEP   = 2'd0;
    localparam logic [1:0] CFG_ATTR_SEP     = 2'd1;
    localparam logic [1:0] CFG_NAME_VAL_SEP = 2'd2;
    localparam logic [1:0] CFG_ARG_SEP      = 2'd3;

    localparam logic [7:0] RST_FILTER_SEP   = 8'd124;
    localparam logic [7:0] RST_ATTR_SEP     = 8'd46;
    localparam logic [7:0] RST_NAME_VAL_SEP = 8'd61;
    localparam logic [7:0] RST_ARG_SEP      = 8'd44;

    // characters
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;

    // roles
    localparam logic [3:0] ROLE_SPACE    = 4'd0;
    localparam logic [3:0] ROLE_VAR      = 4'd1;
    localparam logic [3:0] ROLE_CSTR     = 4'd2;
    localparam logic [3:0] ROLE_NUMBER   = 4'd3;
    localparam logic [3:0] ROLE_ATTR     = 4'd4;
    localparam logic [3:0] ROLE_FNAME    = 4'd5;
    localparam logic [3:0] ROLE_ARG_NAME = 4'd6;
    localparam logic [3:0] ROLE_ARG_VAL  = 4'd7;
    localparam logic [3:0] ROLE_SEP      = 4'd8;
    localparam logic [3:0] ROLE_REJECT   = 4'd9;

    typedef enum logic [4:0] {
        S_BEGIN       = 5'd0,
        S_VAR         = 5'd1,
        S_ATTR_BEGIN  = 5'd2,
        S_ATTR        = 5'd3,
        S_CSTR        = 5'd4,
        S_NSIGN       = 5'd5,
        S_NINT        = 5'd6,
        S_NDOT        = 5'd7,
        S_NFRAC       = 5'd8,
        S_FSEP        = 5'd9,
        S_FNAME_BEGIN = 5'd10,
        S_FNAME       = 5'd11,
        S_PNAME_BEGIN = 5'd12,
        S_PNAME       = 5'd13,
        S_PVAL_BEGIN  = 5'd14,
        S_PVAR        = 5'd15,
        S_PSTR        = 5'd16,
        S_PSIGN       = 5'd17,
        S_PINT        = 5'd18,
        S_PDOT        = 5'd19,
        S_PFRAC       = 5'd20,
        S_PSEP        = 5'd21,
        S_FAILED      = 5'd22
    } t_state;

    typedef struct packed {
        logic [7:0] flt_sep;
        logic [7:0] attr_sep;
        logic [7:0] name_val_sep;
        logic [7:0] arg_sep;
    } t_cfg;

    typedef struct packed {
        logic [3:0] role;
        logic       starts_part;
        logic       value_is_const;
        logic       attr_done;
        logic       arg_done;
        logic       filter_done;
        logic       error;
    } t_flags;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_name_begin(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_name_begin(c) || is_digit(c);
    endfunction

endpackage

/* hw/rtl/fet_parser.sv */
// ---------------------------------------------------------------------------
// fet_parser
// Parse state, position and error registers; tags one character per cycle, advancing only on accept.
// ---------------------------------------------------------------------------
module fet_parser #(
    parameter int MAX_EXPR_LEN = fet_pkg::MAX_EXPR_LEN_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic [7:0]                             i_char_code,
    input  logic                                   i_end_of_expr,
    input  fet_pkg::t_cfg                          i_cfg,
    output fet_pkg::t_flags                        o_flags,
    output logic [$clog2(MAX_EXPR_LEN+1)-1:0]      o_error_pos
);
    import fet_pkg::*;

    localparam int POS_W = $clog2(MAX_EXPR_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_EXPR_LEN);

    t_state           r_state;
    logic [7:0]       r_quote;
    logic             r_arg_const;
    logic             r_main_const;
    logic [POS_W-1:0] r_pos;
    logic             r_err;
    logic [POS_W-1:0] r_err_pos;

    t_state           w_step;
    t_state           n_state;
    logic [7:0]       n_quote;
    logic             n_arg_const;
    logic             n_main_const;
    logic             w_bad;
    logic [POS_W-1:0] w_pos_inc;
    logic             w_argctx;
    logic [7:0]       c;

    assign c         = i_char_code;
    assign w_pos_inc = (r_pos < MAX_POS) ? (r_pos + 1'b1) : r_pos;
    assign w_argctx  = (r_state >= S_PNAME_BEGIN) && (r_state <= S_PSEP);

    // next state
    always_comb begin
        logic bad;
        logic p;
        bad          = 1'b0;
        p            = (r_state == S_PVAL_BEGIN);
        w_step       = r_state;
        n_quote      = r_quote;
        n_arg_const  = r_arg_const;
        n_main_const = r_main_const;
        if (r_state == S_FAILED) begin
            w_step = S_FAILED;
        end else if (c == CH_SPACE && r_state != S_CSTR && r_state != S_PSTR) begin
            case (r_state)
                S_NINT, S_NFRAC: w_step = S_FSEP;
                S_PINT, S_PFRAC: w_step = S_PSEP;
                S_NSIGN, S_NDOT, S_PSIGN, S_PDOT: bad = 1'b1;
                default: w_step = r_state;
            endcase
        end else begin
            case (r_state)
                S_BEGIN, S_PVAL_BEGIN: begin
                    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        n_quote = c;
                        w_step  = p ? S_PSTR : S_CSTR;
                        if (p) n_arg_const = 1'b1; else n_main_const = 1'b1;
                    end else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
                        if (p) w_step = is_digit(c) ? S_PINT : S_PSIGN;
                        else   w_step = is_digit(c) ? S_NINT : S_NSIGN;
                        if (p) n_arg_const = 1'b1; else n_main_const = 1'b1;
                    end else if (is_name_begin(c)) begin
                        w_step = p ? S_PVAR : S_VAR;
                        if (p) n_arg_const = 1'b0; else n_main_const = 1'b0;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_VAR, S_ATTR: begin
                    if (is_name_char(c))              w_step = r_state;
                    else if (c == i_cfg.attr_sep)     w_step = S_ATTR_BEGIN;
                    else if (c == i_cfg.flt_sep)      w_step = S_FNAME_BEGIN;
                    else                              bad = 1'b1;
                end
                S_ATTR_BEGIN: begin
                    if (is_name_begin(c)) w_step = S_ATTR; else bad = 1'b1;
                end
                S_CSTR: begin
                    if (c == r_quote) w_step = S_FSEP;
                end
                S_PSTR: begin
                    if (c == r_quote) w_step = S_PSEP;
                end
                S_NSIGN, S_NDOT, S_PSIGN, S_PDOT: begin
                    if (!is_digit(c))             bad = 1'b1;
                    else if (r_state == S_NSIGN)  w_step = S_NINT;
                    else if (r_state == S_NDOT)   w_step = S_NFRAC;
                    else if (r_state == S_PSIGN)  w_step = S_PINT;
                    else                          w_step = S_PFRAC;
                end
                S_NINT, S_NFRAC, S_FSEP: begin
                    if (r_state != S_FSEP && is_digit(c))     w_step = r_state;
                    else if (r_state == S_NINT && c == CH_DOT) w_step = S_NDOT;
                    else if (c == i_cfg.flt_sep)              w_step = S_FNAME_BEGIN;
                    else                                      bad = 1'b1;
                end
                S_FNAME_BEGIN: begin
                    if (is_name_begin(c)) w_step = S_FNAME; else bad = 1'b1;
                end
                S_FNAME: begin
                    if (is_name_char(c))     w_step = S_FNAME;
                    else if (c == CH_LPAREN) w_step = S_PNAME_BEGIN;
                    else                     bad = 1'b1;
                end
                S_PNAME_BEGIN: begin
                    if (is_name_begin(c)) begin
                        n_arg_const = 1'b0;
                        w_step      = S_PNAME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_PNAME: begin
                    if (is_name_char(c))               w_step = S_PNAME;
                    else if (c == i_cfg.name_val_sep)  w_step = S_PVAL_BEGIN;
                    else                               bad = 1'b1;
                end
                default: begin
                    if (r_state == S_PVAR && is_name_char(c))
                        w_step = r_state;
                    else if ((r_state == S_PINT || r_state == S_PFRAC) && is_digit(c))
                        w_step = r_state;
                    else if (r_state == S_PINT && c == CH_DOT)
                        w_step = S_PDOT;
                    else if (c == i_cfg.arg_sep)
                        w_step = S_PNAME_BEGIN;
                    else if (c == CH_RPAREN)
                        w_step = S_FSEP;
                    else
                        bad = 1'b1;
                end
            endcase
        end
        // unfinished number at the last character
        if (!bad && i_end_of_expr &&
            (w_step == S_NSIGN || w_step == S_NDOT || w_step == S_PSIGN ||
             w_step == S_PINT || w_step == S_PDOT || w_step == S_PFRAC))
            bad = 1'b1;
        w_bad   = bad;
        n_state = bad ? S_FAILED : w_step;
    end

    // outputs
    always_comb begin
        logic p;
        p       = (r_state == S_PVAL_BEGIN);
        o_flags = '0;
        o_flags.role = ROLE_REJECT;
        if (r_state == S_FAILED) begin
            o_flags.role = ROLE_REJECT;
        end else if (c == CH_SPACE && r_state != S_CSTR && r_state != S_PSTR) begin
            o_flags.role = ROLE_SPACE;
        end else begin
            case (r_state)
                S_BEGIN, S_PVAL_BEGIN: begin
                    o_flags.starts_part = 1'b1;
                    if (c == CH_DQUOTE || c == CH_SQUOTE)
                        o_flags.role = p ? ROLE_ARG_VAL : ROLE_CSTR;
                    else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS)
                        o_flags.role = p ? ROLE_ARG_VAL : ROLE_NUMBER;
                    else if (is_name_begin(c))
                        o_flags.role = p ? ROLE_ARG_VAL : ROLE_VAR;
                end
                S_VAR, S_ATTR: begin
                    if (is_name_char(c)) begin
                        o_flags.role = (r_state == S_VAR) ? ROLE_VAR : ROLE_ATTR;
                    end else if (c == i_cfg.attr_sep || c == i_cfg.flt_sep) begin
                        o_flags.role      = ROLE_SEP;
                        o_flags.attr_done = (r_state == S_ATTR);
                    end
                end
                S_ATTR_BEGIN: begin
                    o_flags.role        = ROLE_ATTR;
                    o_flags.starts_part = 1'b1;
                end
                S_CSTR: o_flags.role = ROLE_CSTR;
                S_PSTR: o_flags.role = ROLE_ARG_VAL;
                S_NSIGN, S_NDOT: o_flags.role = ROLE_NUMBER;
                S_PSIGN, S_PDOT: o_flags.role = ROLE_ARG_VAL;
                S_NINT, S_NFRAC, S_FSEP: begin
                    if (r_state != S_FSEP && is_digit(c))      o_flags.role = ROLE_NUMBER;
                    else if (r_state == S_NINT && c == CH_DOT) o_flags.role = ROLE_NUMBER;
                    else                                       o_flags.role = ROLE_SEP;
                end
                S_FNAME_BEGIN: begin
                    o_flags.role        = ROLE_FNAME;
                    o_flags.starts_part = 1'b1;
                end
                S_FNAME: begin
                    o_flags.role = is_name_char(c) ? ROLE_FNAME : ROLE_SEP;
                end
                S_PNAME_BEGIN: begin
                    o_flags.role        = ROLE_ARG_NAME;
                    o_flags.starts_part = 1'b1;
                end
                S_PNAME: begin
                    o_flags.role = is_name_char(c) ? ROLE_ARG_NAME : ROLE_SEP;
                end
                default: begin
                    if ((r_state == S_PVAR && is_name_char(c)) ||
                        ((r_state == S_PINT || r_state == S_PFRAC) && is_digit(c)) ||
                        (r_state == S_PINT && c == CH_DOT)) begin
                        o_flags.role = ROLE_ARG_VAL;
                    end else begin
                        o_flags.role        = ROLE_SEP;
                        o_flags.arg_done    = 1'b1;
                        o_flags.filter_done = (c != i_cfg.arg_sep);
                    end
                end
            endcase
        end
        if (w_bad) begin
            o_flags.role        = ROLE_REJECT;
            o_flags.starts_part = 1'b0;
            o_flags.attr_done   = 1'b0;
            o_flags.arg_done    = 1'b0;
            o_flags.filter_done = 1'b0;
        end
        o_flags.value_is_const = w_argctx ? n_arg_const : n_main_const;
        o_flags.error          = r_err | w_bad;
        o_error_pos = r_err ? r_err_pos : (w_bad ? w_pos_inc : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_BEGIN;
            r_quote      <= CH_DQUOTE;
            r_arg_const  <= 1'b0;
            r_main_const <= 1'b0;
            r_pos        <= '0;
            r_err        <= 1'b0;
            r_err_pos    <= '0;
        end else if (i_accept) begin
            if (w_bad && !r_err) begin
                r_err     <= 1'b1;
                r_err_pos <= w_pos_inc;
            end
            if (i_end_of_expr) begin
                r_state      <= S_BEGIN;
                r_quote      <= CH_DQUOTE;
                r_arg_const  <= 1'b0;
                r_main_const <= 1'b0;
                r_pos        <= '0;
            end else begin
                r_state      <= n_state;
                r_quote      <= n_quote;
                r_arg_const  <= n_arg_const;
                r_main_const <= n_main_const;
                r_pos        <= w_pos_inc;
            end
        end
    end

endmodule

/* hw/rtl/filter_expression_tokenizer.sv */
// ---------------------------------------------------------------------------
// filter_expression_tokenizer
// Tags each character of a var.attr|filter(name=value,...) expression.
// ---------------------------------------------------------------------------
// Each accepted character's tags are registered in a two-entry output queue.
// Throughput: 1 item per cycle while the skid entry is empty (o_in_ready high).
// The queue's skid entry keeps input flowing for one more item during an output stall.
// Reset (sync, active low): parser at expression begin, error cleared,
// separators at their default characters, output queue empty.
module filter_expression_tokenizer #(
    parameter int MAX_EXPR_LEN = fet_pkg::MAX_EXPR_LEN_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_char_code,
    input  logic                               i_end_of_expr,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [3:0]                         o_role,
    output logic                               o_starts_part,
    output logic                               o_value_is_const,
    output logic                               o_attr_done,
    output logic                               o_arg_done,
    output logic                               o_filter_done,
    output logic                               o_error,
    output logic [$clog2(MAX_EXPR_LEN+1)-1:0]  o_error_pos
);
    import fet_pkg::*;

    localparam int POS_W = $clog2(MAX_EXPR_LEN + 1);

    t_cfg             r_cfg;
    t_flags           w_flags;
    logic [POS_W-1:0] w_pos;
    logic             w_in_acc;
    logic             w_out_pop;

    logic             r_out_valid;
    t_flags           r_out_flags;
    logic [POS_W-1:0] r_out_pos;
    logic             r_skid_valid;
    t_flags           r_skid_flags;
    logic [POS_W-1:0] r_skid_pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_pop   = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flt_sep      <= RST_FILTER_SEP;
            r_cfg.attr_sep     <= RST_ATTR_SEP;
            r_cfg.name_val_sep <= RST_NAME_VAL_SEP;
            r_cfg.arg_sep      <= RST_ARG_SEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILTER_SEP:   r_cfg.flt_sep      <= i_cfg_data;
                CFG_ATTR_SEP:     r_cfg.attr_sep     <= i_cfg_data;
                CFG_NAME_VAL_SEP: r_cfg.name_val_sep <= i_cfg_data;
                CFG_ARG_SEP:      r_cfg.arg_sep      <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    fet_parser #(
        .MAX_EXPR_LEN(MAX_EXPR_LEN)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_acc),
        .i_char_code  (i_char_code),
        .i_end_of_expr(i_end_of_expr),
        .i_cfg        (r_cfg),
        .o_flags      (w_flags),
        .o_error_pos  (w_pos)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            if (!r_out_valid || w_out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (!r_out_valid || w_out_pop) begin
                r_out_flags <= w_flags;
                r_out_pos   <= w_pos;
            end else begin
                r_skid_flags <= w_flags;
                r_skid_pos   <= w_pos;
            end
        end else if (w_out_pop && r_skid_valid) begin
            r_out_flags <= r_skid_flags;
            r_out_pos   <= r_skid_pos;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_role           = r_out_flags.role;
    assign o_starts_part    = r_out_flags.starts_part;
    assign o_value_is_const = r_out_flags.value_is_const;
    assign o_attr_done      = r_out_flags.attr_done;
    assign o_arg_done       = r_out_flags.arg_done;
    assign o_filter_done    = r_out_flags.filter_done;
    assign o_error          = r_out_flags.error;
    assign o_error_pos      = r_out_pos;

endmodule

/* hw/rtl/fet_checker.sv */
// ---------------------------------------------------------------------------
// fet_checker
// Port-level checks of the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "filter_expression_tokenizer_defines.svh"

module fet_checker #(
    parameter int POS_W = 13
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [3:0]       o_role,
    input logic             o_starts_part,
    input logic             o_attr_done,
    input logic             o_arg_done,
    input logic             o_filter_done,
    input logic             o_error,
    input logic [POS_W-1:0] o_error_pos
);
    import fet_pkg::*;

    logic r_seen_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_error) begin
            r_seen_err <= 1'b1;
        end
    end

    `FET_ASSERT_NOW(a_err_sticky, i_clk, i_rst_n, o_out_valid && r_seen_err, o_error, "error flag dropped")
    `FET_ASSERT_NOW(a_err_pos, i_clk, i_rst_n, o_out_valid, o_error == (o_error_pos != '0), "error position disagrees with flag")
    `FET_ASSERT_NOW(a_reject_flags, i_clk, i_rst_n, o_out_valid && o_role == ROLE_REJECT, !o_starts_part && !o_attr_done && !o_arg_done && !o_filter_done, "rejected item carries flags")
    `FET_ASSERT_NOW(a_filter_end, i_clk, i_rst_n, o_out_valid && o_filter_done, o_arg_done && o_role == ROLE_SEP, "filter end without argument end")
    `FET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_role) && $stable(o_error_pos), "stalled item changed")

endmodule

bind filter_expression_tokenizer fet_checker #(.POS_W(POS_W)) u_fet_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Filter expression tokenizer testbench
// Streams expressions through the tokenizer one character per item and checks
// the tag of every character against a cycle-free predictor of the parser.
// Covers a few hand-written expressions and random well-formed and damaged
// expressions under several separator settings, with bursty input and output
// stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fet_pkg::*;

    localparam int MAX_LEN        = MAX_EXPR_LEN_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 50;

    localparam logic [7:0] CH_A_LO  = "a";
    localparam logic [7:0] CH_A_UP  = "A";
    localparam logic [7:0] CH_ZERO  = "0";

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_char_item;

    typedef struct packed {
        logic [3:0]  role;
        logic        starts_part;
        logic        value_is_const;
        logic        attr_done;
        logic        arg_done;
        logic        filter_done;
        logic        error;
        logic [12:0] error_pos;
    } t_token;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_FILTER_SEP;
    logic [7:0]  i_cfg_data    = 8'h00;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_char_code   = 8'h00;
    logic        i_end_of_expr = 1'b0;
    logic        i_out_ready   = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_role;
    logic        o_starts_part;
    logic        o_value_is_const;
    logic        o_attr_done;
    logic        o_arg_done;
    logic        o_filter_done;
    logic        o_error;
    logic [12:0] o_error_pos;

    filter_expression_tokenizer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_char_code      (i_char_code),
        .i_end_of_expr    (i_end_of_expr),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_role           (o_role),
        .o_starts_part    (o_starts_part),
        .o_value_is_const (o_value_is_const),
        .o_attr_done      (o_attr_done),
        .o_arg_done       (o_arg_done),
        .o_filter_done    (o_filter_done),
        .o_error          (o_error),
        .o_error_pos      (o_error_pos)
    );

    always #5 i_clk = ~i_clk;

    t_char_item  pending_chars [$];
    t_token      expected_tokens [$];
    logic [7:0]  expr_buf [$];
    int          mismatch_count = 0;

    // separator registers as last written
    logic [7:0]  sep_filter   = RST_FILTER_SEP;
    logic [7:0]  sep_attr     = RST_ATTR_SEP;
    logic [7:0]  sep_name_val = RST_NAME_VAL_SEP;
    logic [7:0]  sep_arg      = RST_ARG_SEP;

    // parser state
    t_state      tk_state      = S_BEGIN;
    logic [7:0]  tk_quote      = CH_DQUOTE;
    int          tk_pos        = 0;
    logic        tk_err        = 1'b0;
    logic [12:0] tk_err_pos    = '0;
    logic        tk_arg_const  = 1'b0;
    logic        tk_main_const = 1'b0;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return ((c >= CH_A_LO) && (c <= CH_A_LO + 8'd25)) ||
               ((c >= CH_A_UP) && (c <= CH_A_UP + 8'd25)) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_word_start(c) || is_dec(c);
    endfunction

    function automatic t_token tokenize_char(input logic [7:0] c, input logic last);
        t_token t;
        t_state s;
        logic   bad;
        logic   in_args;
        logic   p;
        logic   was_attr;
        s        = tk_state;
        t        = '0;
        t.role   = ROLE_REJECT;
        bad      = 1'b0;
        in_args  = (s >= S_PNAME_BEGIN) && (s <= S_PSEP);
        if (tk_pos < MAX_LEN) tk_pos++;

        if (s == S_FAILED) begin
            t.role = ROLE_REJECT;
        end else if (c == CH_SPACE && s != S_CSTR && s != S_PSTR) begin
            t.role = ROLE_SPACE;
            case (s)
                S_NINT, S_NFRAC: s = S_FSEP;
                S_PINT, S_PFRAC: s = S_PSEP;
                S_NSIGN, S_NDOT, S_PSIGN, S_PDOT: bad = 1'b1;
                default: ;
            endcase
        end else begin
            case (s)
                S_BEGIN, S_PVAL_BEGIN: begin
                    p = (s == S_PVAL_BEGIN);
                    t.starts_part = 1'b1;
                    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        tk_quote = c;
                        if (p) begin
                            s = S_PSTR;
                            t.role = ROLE_ARG_VAL;
                            tk_arg_const = 1'b1;
                        end else begin
                            s = S_CSTR;
                            t.role = ROLE_CSTR;
                            tk_main_const = 1'b1;
                        end
                    end else if (is_dec(c) || c == CH_PLUS || c == CH_MINUS) begin
                        if (p) begin
                            s = is_dec(c) ? S_PINT : S_PSIGN;
                            t.role = ROLE_ARG_VAL;
                            tk_arg_const = 1'b1;
                        end else begin
                            s = is_dec(c) ? S_NINT : S_NSIGN;
                            t.role = ROLE_NUMBER;
                            tk_main_const = 1'b1;
                        end
                    end else if (is_word_start(c)) begin
                        if (p) begin
                            s = S_PVAR;
                            t.role = ROLE_ARG_VAL;
                            tk_arg_const = 1'b0;
                        end else begin
                            s = S_VAR;
                            t.role = ROLE_VAR;
                            tk_main_const = 1'b0;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_VAR, S_ATTR: begin
                    was_attr = (s == S_ATTR);
                    if (is_word_char(c)) begin
                        t.role = was_attr ? ROLE_ATTR : ROLE_VAR;
                    end else if (c == sep_attr) begin
                        t.role = ROLE_SEP;
                        s = S_ATTR_BEGIN;
                        t.attr_done = was_attr;
                    end else if (c == sep_filter) begin
                        t.role = ROLE_SEP;
                        s = S_FNAME_BEGIN;
                        t.attr_done = was_attr;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_ATTR_BEGIN: begin
                    if (is_word_start(c)) begin
                        t.role = ROLE_ATTR;
                        t.starts_part = 1'b1;
                        s = S_ATTR;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_CSTR: begin
                    t.role = ROLE_CSTR;
                    if (c == tk_quote) s = S_FSEP;
                end
                S_PSTR: begin
                    t.role = ROLE_ARG_VAL;
                    if (c == tk_quote) s = S_PSEP;
                end
                S_NSIGN, S_NDOT, S_PSIGN, S_PDOT: begin
                    if (is_dec(c)) begin
                        p = (s == S_PSIGN) || (s == S_PDOT);
                        t.role = p ? ROLE_ARG_VAL : ROLE_NUMBER;
                        case (s)
                            S_NSIGN: s = S_NINT;
                            S_NDOT:  s = S_NFRAC;
                            S_PSIGN: s = S_PINT;
                            default: s = S_PFRAC;
                        endcase
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_NINT, S_NFRAC, S_FSEP: begin
                    if (s != S_FSEP && is_dec(c)) begin
                        t.role = ROLE_NUMBER;
                    end else if (s == S_NINT && c == CH_DOT) begin
                        t.role = ROLE_NUMBER;
                        s = S_NDOT;
                    end else if (c == sep_filter) begin
                        t.role = ROLE_SEP;
                        s = S_FNAME_BEGIN;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_FNAME_BEGIN: begin
                    if (is_word_start(c)) begin
                        t.role = ROLE_FNAME;
                        t.starts_part = 1'b1;
                        s = S_FNAME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_FNAME: begin
                    if (is_word_char(c)) begin
                        t.role = ROLE_FNAME;
                    end else if (c == CH_LPAREN) begin
                        t.role = ROLE_SEP;
                        s = S_PNAME_BEGIN;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_PNAME_BEGIN: begin
                    if (is_word_start(c)) begin
                        t.role = ROLE_ARG_NAME;
                        t.starts_part = 1'b1;
                        tk_arg_const = 1'b0;
                        s = S_PNAME;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_PNAME: begin
                    if (is_word_char(c)) begin
                        t.role = ROLE_ARG_NAME;
                    end else if (c == sep_name_val) begin
                        t.role = ROLE_SEP;
                        s = S_PVAL_BEGIN;
                    end else begin
                        bad = 1'b1;
                    end
                end
                S_PVAR, S_PINT, S_PFRAC, S_PSEP: begin
                    if (s == S_PVAR && is_word_char(c)) begin
                        t.role = ROLE_ARG_VAL;
                    end else if ((s == S_PINT || s == S_PFRAC) && is_dec(c)) begin
                        t.role = ROLE_ARG_VAL;
                    end else if (s == S_PINT && c == CH_DOT) begin
                        t.role = ROLE_ARG_VAL;
                        s = S_PDOT;
                    end else if (c == sep_arg) begin
                        t.role = ROLE_SEP;
                        t.arg_done = 1'b1;
                        s = S_PNAME_BEGIN;
                    end else if (c == CH_RPAREN) begin
                        t.role = ROLE_SEP;
                        t.arg_done = 1'b1;
                        t.filter_done = 1'b1;
                        s = S_FSEP;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // a number cut off by the end of the expression
        if (!bad && last && (s == S_NSIGN || s == S_NDOT ||
                             (s >= S_PSIGN && s <= S_PFRAC))) bad = 1'b1;

        if (bad) begin
            t.role        = ROLE_REJECT;
            t.starts_part = 1'b0;
            t.attr_done   = 1'b0;
            t.arg_done    = 1'b0;
            t.filter_done = 1'b0;
            s             = S_FAILED;
            if (!tk_err) begin
                tk_err     = 1'b1;
                tk_err_pos = tk_pos[12:0];
            end
        end

        t.value_is_const = in_args ? tk_arg_const : tk_main_const;
        t.error          = tk_err;
        t.error_pos      = tk_err_pos;
        tk_state         = s;

        if (last) begin
            tk_state      = S_BEGIN;
            tk_pos        = 0;
            tk_quote      = CH_DQUOTE;
            tk_arg_const  = 1'b0;
            tk_main_const = 1'b0;
        end
        return t;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] val);
        case (idx)
            CFG_FILTER_SEP:   sep_filter   = val;
            CFG_ATTR_SEP:     sep_attr     = val;
            CFG_NAME_VAL_SEP: sep_name_val = val;
            CFG_ARG_SEP:      sep_arg      = val;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [12:0] got,
                               input logic [12:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------- input driver ----------------
    t_char_item next_char;
    t_token     pred_token;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pred_token = tokenize_char(i_char_code, i_end_of_expr);
                expected_tokens.insert(expected_tokens.size(), pred_token);
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    next_char = pending_chars.pop_front();
                    i_in_valid    <= 1'b1;
                    i_char_code   <= next_char.char_code;
                    i_end_of_expr <= next_char.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- output stall pattern ----------------
    int stall_phase  = 0;
    int stall_period = 0;
    int stall_len    = 0;

    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_period = $urandom_range(2, 12);
            stall_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
            stall_phase  = stall_period;
        end
        i_out_ready <= (stall_phase <= stall_len) ? 1'b0 : 1'b1;
        stall_phase--;
    end

    // ---------------- result monitor ----------------
    t_token want_token;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want_token = expected_tokens.pop_front();
                check_field("role", 13'(o_role), 13'(want_token.role));
                check_field("starts_part", 13'(o_starts_part), 13'(want_token.starts_part));
                check_field("value_is_const", 13'(o_value_is_const),
                            13'(want_token.value_is_const));
                check_field("attr_done", 13'(o_attr_done), 13'(want_token.attr_done));
                check_field("arg_done", 13'(o_arg_done), 13'(want_token.arg_done));
                check_field("filter_done", 13'(o_filter_done), 13'(want_token.filter_done));
                check_field("error", 13'(o_error), 13'(want_token.error));
                check_field("error_pos", o_error_pos, want_token.error_pos);
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_char(input logic [7:0] c, input logic last);
        t_char_item it;
        it.char_code = c;
        it.last      = last;
        pending_chars.insert(pending_chars.size(), it);
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) push_char(text[i], i == text.len() - 1);
    endtask

    task automatic push_expression();
        for (int i = 0; i < expr_buf.size(); i++) push_char(expr_buf[i], i == expr_buf.size() - 1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    task automatic program_regs(input logic [7:0] f, input logic [7:0] a,
                                input logic [7:0] nv, input logic [7:0] ar);
        write_reg(CFG_FILTER_SEP, f);
        write_reg(CFG_ATTR_SEP, a);
        write_reg(CFG_NAME_VAL_SEP, nv);
        write_reg(CFG_ARG_SEP, ar);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || i_in_valid || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_char(input logic [7:0] ch);
        expr_buf.insert(expr_buf.size(), ch);
    endfunction

    function automatic logic [7:0] pick_word_start();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return CH_A_LO + r[7:0];
        if (r < 52) return CH_A_UP + r[7:0] - 8'd26;
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] pick_from(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic void add_gap();
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) add_char(CH_SPACE);
    endfunction

    function automatic void add_name();
        add_char(pick_word_start());
        repeat ($urandom_range(0, 5))
            add_char(($urandom_range(0, 4) == 0) ?
                     CH_ZERO + 8'($urandom_range(0, 9)) : pick_word_start());
    endfunction

    function automatic void add_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // returns 1 when the value is a name
    function automatic logic add_value();
        logic [7:0] q;
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                add_char(q);
                repeat ($urandom_range(0, 6)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == q);
                    add_char(b);
                end
                add_char(q);
                return 1'b0;
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: add_char(CH_PLUS);
                    1: add_char(CH_MINUS);
                    default: ;
                endcase
                add_digits(1, 4);
                if ($urandom_range(0, 1)) begin
                    add_char(CH_DOT);
                    add_digits(1, 3);
                end
                return 1'b0;
            end
            default: begin
                add_name();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void build_expression();
        int nargs;
        int pos;
        expr_buf.delete();
        add_gap();
        if (add_value()) begin
            repeat ($urandom_range(0, 2)) begin
                add_char(sep_attr);
                add_name();
            end
        end
        repeat ($urandom_range(0, 2)) begin
            add_gap();
            add_char(sep_filter);
            add_gap();
            add_name();
            if ($urandom_range(0, 2) != 0) begin
                add_char(CH_LPAREN);
                nargs = $urandom_range(1, 3);
                for (int k = 0; k < nargs; k++) begin
                    add_gap();
                    add_name();
                    add_char(sep_name_val);
                    add_gap();
                    void'(add_value());
                    add_gap();
                    if (k < nargs - 1) add_char(sep_arg);
                end
                add_char(CH_RPAREN);
            end
        end
        add_gap();
        // damaged expressions: stray byte, early end or stray space
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, expr_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: expr_buf[pos] = 8'($urandom_range(0, 255));
                1: while (expr_buf.size() > pos + 1) void'(expr_buf.pop_back());
                default: expr_buf.insert(pos, CH_SPACE);
            endcase
        end
    endfunction

    initial begin
        int queued;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_text("v.a|f(n=-2)");
        push_text("'q'");
        push_text("+1 x");
        push_text("-");
        push_text("1.5");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: program_regs(8'h00, 8'h00, 8'h00, 8'h00);
                1: program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: program_regs(pick_from("aZ_09.() \"'+-"), pick_from("aZ_09.() \"'+-"),
                                pick_from("aZ_09.() \"'+-"), pick_from("aZ_09.() \"'+-"));
                3: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                4: program_regs(pick_from(":;/#@!&^~"), pick_from(":;/#@!&^~"),
                                pick_from(":;/#@!&^~"), pick_from(":;/#@!&^~"));
                default: program_regs(RST_FILTER_SEP, RST_ATTR_SEP,
                                      RST_NAME_VAL_SEP, RST_ARG_SEP);
            endcase
            queued = 0;
            while (queued < 220) begin
                build_expression();
                queued += expr_buf.size();
                push_expression();
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
